@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the resizer top level; ASSERT_OFF removes them all.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");
// antecedent in one cycle forces the consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst, cond)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/core/nnr_pkg.sv @@
// ----------------------------------------------------------------------------
// nnr_pkg
// Shared types and fixed constants of the nearest-neighbour resizer.
// ----------------------------------------------------------------------------
package nnr_pkg;

  // fixed field widths
  localparam int PIX_W     = 8;
  localparam int COORD_W   = 8;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_RESET = 28;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_TARGET_WIDTH  = 2'd2,
    REG_TARGET_HEIGHT = 2'd3
  } cfg_reg_t;

  // request class decided by the front end
  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_READ      = 2'd1,
    OP_RANGE_ERR = 2'd2
  } op_t;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_DIV   = 2'd1,
    BK_FETCH = 2'd2,
    BK_RESP  = 2'd3
  } back_state_t;

  // queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

@@ rtl/core/nnr_ifs.sv @@
// ----------------------------------------------------------------------------
// nnr_ifs
// Request, response and configuration channels of the resizer.
// ----------------------------------------------------------------------------

// request channel: pixel write or resized pixel read
interface nnr_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] src_col;
  logic [7:0] src_row;
  logic [7:0] pixel_in;
  logic [7:0] dst_col;
  logic [7:0] dst_row;

  modport source (output valid, req_type, src_col, src_row, pixel_in, dst_col, dst_row,
                  input ready);
  modport sink (input valid, req_type, src_col, src_row, pixel_in, dst_col, dst_row,
                output ready);
endinterface

// response channel: one result per read request
interface nnr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       coord_error;

  modport source (output valid, pixel_out, coord_error, input ready);
  modport sink (input valid, pixel_out, coord_error, output ready);
endinterface

// configuration write channel
interface nnr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/nearest_neighbor_image_resize.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_image_resize
// Nearest-neighbour image resizer with an on-chip frame store.
// ----------------------------------------------------------------------------
// A write request stores one 8-bit pixel at its source column and row; a
// write outside the configured source size is dropped at the front. A read
// request maps the destination position to the source with truncating
// division and returns the stored pixel: the restoring divider yields one
// quotient bit per cycle, then the frame store read port and the result
// register are loaded in turn, the latter once the previous result is taken.
// A read outside the target size returns zero with coord_error set. The
// front accepts one request per cycle into a two-entry queue while the back
// end works and the queue has room, and the result register lets the next
// request start while a result waits.
// Dimension registers are clamped to 1..MAX_DIM when written and may only be
// changed while the block is idle; reading a pixel that was never written
// returns an undefined value.
`include "assert_macros.svh"

module nearest_neighbor_image_resize #(
  parameter int MAX_DIM = 256
) (
  input logic     clk,
  input logic     rst,
  nnr_req_if.sink   req,
  nnr_rsp_if.source rsp,
  nnr_cfg_if.sink   cfg
);

  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int NUM_W   = nnr_pkg::COORD_W + DIM_W;
  localparam int ENTRY_W = 2 + 2 * NUM_W + nnr_pkg::PIX_W;
  localparam logic [DIM_W-1:0] DIM_RESET =
    (nnr_pkg::CFG_RESET > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(nnr_pkg::CFG_RESET);

  logic [DIM_W-1:0]       src_w;
  logic [DIM_W-1:0]       src_h;
  logic [DIM_W-1:0]       dst_w;
  logic [DIM_W-1:0]       dst_h;
  logic [DIM_W-1:0]       cfg_dim;
  logic                   push;
  logic                   pop;
  logic [ENTRY_W-1:0]     push_data;
  logic [ENTRY_W-1:0]     pop_data;
  nnr_pkg::queue_status_t q_status;

  // zero reads as one, anything above MAX_DIM as MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(logic [nnr_pkg::CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  // configuration registers hold clamped sizes
  assign cfg.ready = 1'b1;
  assign cfg_dim   = clamp_dim(cfg.data);

  always_ff @(posedge clk) begin
    if (rst) begin
      src_w <= DIM_RESET;
      src_h <= DIM_RESET;
      dst_w <= DIM_RESET;
      dst_h <= DIM_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (nnr_pkg::cfg_reg_t'(cfg.index))
        nnr_pkg::REG_SOURCE_WIDTH:  src_w <= cfg_dim;
        nnr_pkg::REG_SOURCE_HEIGHT: src_h <= cfg_dim;
        nnr_pkg::REG_TARGET_WIDTH:  dst_w <= cfg_dim;
        nnr_pkg::REG_TARGET_HEIGHT: dst_h <= cfg_dim;
        default: begin
        end
      endcase
    end
  end

  // front end
  nnr_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .req       (req),
    .src_w     (src_w),
    .src_h     (src_h),
    .dst_w     (dst_w),
    .dst_h     (dst_h),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue
  nnr_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  // back end
  nnr_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .dst_w    (dst_w),
    .dst_h    (dst_h),
    .q_status (q_status),
    .q_data   (pop_data),
    .pop      (pop),
    .rsp      (rsp)
  );

  // checks
  `ASSERT_ALWAYS(a_err_zero, clk, rst, !(rsp.valid && rsp.coord_error) || (rsp.pixel_out == '0))
  `ASSERT_ALWAYS(a_queue_sane, clk, rst, !(q_status.full && q_status.empty))
  `ASSERT_ALWAYS(a_no_pop_empty, clk, rst, !(pop && q_status.empty))
  `ASSERT_NEXT(a_reset_quiet, clk, rst, 1'b1, !$past(rst) || !rsp.valid)

endmodule

@@ rtl/core/nnr_queue.sv @@
// ----------------------------------------------------------------------------
// nnr_queue
// Two-entry queue between the classifying front end and the back end.
// ----------------------------------------------------------------------------
module nnr_queue #(
  parameter int DATA_W = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [DATA_W-1:0]      push_data,
  input  logic                   pop,
  output logic [DATA_W-1:0]      pop_data,
  output nnr_pkg::queue_status_t status
);

  logic [DATA_W-1:0] slot [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  // status and head of queue
  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign pop_data     = slot[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/core/nnr_front.sv @@
// ----------------------------------------------------------------------------
// nnr_front
// Accepts requests, checks coordinates and forms the division numerators.
// ----------------------------------------------------------------------------
module nnr_front #(
  parameter int MAX_DIM = 256
) (
  nnr_req_if.sink                         req,
  input  logic [$clog2(MAX_DIM+1)-1:0]    src_w,
  input  logic [$clog2(MAX_DIM+1)-1:0]    src_h,
  input  logic [$clog2(MAX_DIM+1)-1:0]    dst_w,
  input  logic [$clog2(MAX_DIM+1)-1:0]    dst_h,
  input  nnr_pkg::queue_status_t          q_status,
  output logic                            push,
  output logic [2+2*(nnr_pkg::COORD_W+$clog2(MAX_DIM+1))+nnr_pkg::PIX_W-1:0] push_data
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int NUM_W = nnr_pkg::COORD_W + DIM_W;

  typedef struct packed {
    nnr_pkg::op_t             op;
    logic [NUM_W-1:0]         num_row;
    logic [NUM_W-1:0]         num_col;
    logic [nnr_pkg::PIX_W-1:0] pixel;
  } entry_t;

  entry_t entry;
  logic   accept;
  logic   wr_ok;
  logic   rd_ok;

  // take a request whenever the queue has room
  assign req.ready = !q_status.full;
  assign accept    = req.valid && req.ready;

  // coordinate range checks
  assign wr_ok = (NUM_W'(req.src_col) < NUM_W'(src_w)) && (NUM_W'(req.src_row) < NUM_W'(src_h));
  assign rd_ok = (NUM_W'(req.dst_col) < NUM_W'(dst_w)) && (NUM_W'(req.dst_row) < NUM_W'(dst_h));

  // classify and build the queue entry; row numerator y*src_h, column x*src_w
  always_comb begin
    entry.pixel = req.pixel_in;
    if (!req.req_type) begin
      entry.op      = nnr_pkg::OP_WRITE;
      entry.num_row = NUM_W'(req.src_row);
      entry.num_col = NUM_W'(req.src_col);
    end else if (rd_ok) begin
      entry.op      = nnr_pkg::OP_READ;
      entry.num_row = NUM_W'(NUM_W'(req.dst_row) * NUM_W'(src_h));
      entry.num_col = NUM_W'(NUM_W'(req.dst_col) * NUM_W'(src_w));
    end else begin
      entry.op      = nnr_pkg::OP_RANGE_ERR;
      entry.num_row = '0;
      entry.num_col = '0;
    end
  end

  // out of range writes are dropped here
  assign push      = accept && (req.req_type || wr_ok);
  assign push_data = entry;

endmodule

@@ rtl/core/nnr_back.sv @@
// ----------------------------------------------------------------------------
// nnr_back
// Runs the coordinate divisions, owns the frame store and the result register.
// ----------------------------------------------------------------------------
module nnr_back #(
  parameter int MAX_DIM = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [$clog2(MAX_DIM+1)-1:0]    dst_w,
  input  logic [$clog2(MAX_DIM+1)-1:0]    dst_h,
  input  nnr_pkg::queue_status_t          q_status,
  input  logic [2+2*(nnr_pkg::COORD_W+$clog2(MAX_DIM+1))+nnr_pkg::PIX_W-1:0] q_data,
  output logic                            pop,
  nnr_rsp_if.source                       rsp
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int NUM_W = nnr_pkg::COORD_W + DIM_W;
  localparam int QW    = $clog2(MAX_DIM);
  localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;
  localparam int CW    = NUM_W + QW;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  typedef struct packed {
    nnr_pkg::op_t             op;
    logic [NUM_W-1:0]         num_row;
    logic [NUM_W-1:0]         num_col;
    logic [nnr_pkg::PIX_W-1:0] pixel;
  } entry_t;

  entry_t                    entry;
  nnr_pkg::back_state_t      state;
  nnr_pkg::back_state_t      state_next;
  logic [NUM_W-1:0]          rem_row;
  logic [NUM_W-1:0]          rem_col;
  logic [NUM_W-1:0]          rem_row_next;
  logic [NUM_W-1:0]          rem_col_next;
  logic [QW-1:0]             quo_row;
  logic [QW-1:0]             quo_col;
  logic [CNT_W-1:0]          cnt;
  logic [CW-1:0]             dsh_row;
  logic [CW-1:0]             dsh_col;
  logic                      ge_row;
  logic                      ge_col;
  logic                      load_div;
  logic                      load_out;
  logic                      out_free;
  logic                      mem_we;
  logic                      rd_en;
  logic [AW-1:0]             wr_addr;
  logic [AW-1:0]             rd_addr;
  logic [nnr_pkg::PIX_W-1:0] rd_data;
  logic [nnr_pkg::PIX_W-1:0] pix_d;
  logic                      err_d;
  logic                      out_valid;
  logic [nnr_pkg::PIX_W-1:0] out_pixel;
  logic                      out_err;
  logic [nnr_pkg::PIX_W-1:0] frame [DEPTH];

  assign entry    = entry_t'(q_data);
  assign out_free = !out_valid || rsp.ready;

  // one restoring step per cycle for each coordinate, quotient msb first
  assign dsh_row      = CW'(dst_h) << cnt;
  assign dsh_col      = CW'(dst_w) << cnt;
  assign ge_row       = CW'(rem_row) >= dsh_row;
  assign ge_col       = CW'(rem_col) >= dsh_col;
  assign rem_row_next = ge_row ? NUM_W'(CW'(rem_row) - dsh_row) : rem_row;
  assign rem_col_next = ge_col ? NUM_W'(CW'(rem_col) - dsh_col) : rem_col;

  // store addresses, row * MAX_DIM + column
  assign wr_addr = AW'(int'(entry.num_row) * MAX_DIM + int'(entry.num_col));
  assign rd_addr = AW'(int'(quo_row) * MAX_DIM + int'(quo_col));

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nnr_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and controls
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    mem_we     = 1'b0;
    rd_en      = 1'b0;
    load_div   = 1'b0;
    load_out   = 1'b0;
    pix_d      = rd_data;
    err_d      = 1'b0;
    case (state)
      nnr_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          case (entry.op)
            nnr_pkg::OP_WRITE: begin
              mem_we = 1'b1;
              pop    = 1'b1;
            end
            nnr_pkg::OP_READ: begin
              load_div   = 1'b1;
              pop        = 1'b1;
              state_next = nnr_pkg::BK_DIV;
            end
            nnr_pkg::OP_RANGE_ERR: begin
              if (out_free) begin
                load_out = 1'b1;
                pix_d    = '0;
                err_d    = 1'b1;
                pop      = 1'b1;
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      nnr_pkg::BK_DIV: begin
        if (cnt == '0) begin
          state_next = nnr_pkg::BK_FETCH;
        end
      end
      nnr_pkg::BK_FETCH: begin
        rd_en      = 1'b1;
        state_next = nnr_pkg::BK_RESP;
      end
      nnr_pkg::BK_RESP: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = nnr_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = nnr_pkg::BK_IDLE;
      end
    endcase
  end

  // divider datapath
  always_ff @(posedge clk) begin
    if (load_div) begin
      rem_row <= entry.num_row;
      rem_col <= entry.num_col;
      quo_row <= '0;
      quo_col <= '0;
      cnt     <= CNT_W'(QW - 1);
    end else if (state == nnr_pkg::BK_DIV) begin
      rem_row <= rem_row_next;
      rem_col <= rem_col_next;
      quo_row <= QW'({quo_row, ge_row});
      quo_col <= QW'({quo_col, ge_col});
      cnt     <= cnt - CNT_W'(1);
    end
  end

  // frame store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame[wr_addr] <= entry.pixel;
    end
    if (rd_en) begin
      rd_data <= frame[rd_addr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_pixel <= pix_d;
      out_err   <= err_d;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.pixel_out   = out_pixel;
  assign rsp.coord_error = out_err;

endmodule

@@ test/tb_nearest_neighbor_image_resize.sv @@
// ----------------------------------------------------------------------------
// tb_nearest_neighbor_image_resize
// Self-checking bench for the nearest-neighbour resizer: a scoreboard keeps
// its own frame store and dimension registers, predicts every read result and
// checks responses in order while both channels stall at random outside a calm phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_nearest_neighbor_image_resize;

  localparam int DIM       = 256;
  localparam int CFG_BITS  = nnr_pkg::CFG_W;
  localparam int DRAIN_CYC = 16;
  localparam int PHASE_LEN = 112;

  typedef enum bit {
    REQ_WRITE = 1'b0,
    REQ_READ  = 1'b1
  } req_kind_t;

  typedef struct {
    req_kind_t kind;
    bit [7:0]  src_col;
    bit [7:0]  src_row;
    bit [7:0]  pixel_in;
    bit [7:0]  dst_col;
    bit [7:0]  dst_row;
  } pixel_req_t;

  typedef struct {
    bit [7:0] pixel;
    bit       coord_error;
  } pixel_rsp_t;

  // shadow frame store, dimension registers and queue of awaited pixels
  class resize_scoreboard;
    bit [CFG_BITS-1:0] regs [4];
    bit [7:0]          store [DIM*DIM];
    pixel_rsp_t        awaited [$];
    int                errors;

    function new();
      foreach (regs[i]) regs[i] = CFG_BITS'(nnr_pkg::CFG_RESET);
      errors = 0;
    endfunction

    // dimension as the block uses it, clamped to 1..DIM
    function int dim(nnr_pkg::cfg_reg_t idx);
      int v;
      v = int'(regs[idx]);
      if (v == 0) return 1;
      if (v > DIM) return DIM;
      return v;
    endfunction

    function void write_reg(nnr_pkg::cfg_reg_t idx, bit [CFG_BITS-1:0] value);
      regs[idx] = value;
    endfunction

    function void note_request(pixel_req_t r);
      int sw, sh, dw, dh, sx, sy;
      pixel_rsp_t res;
      sw = dim(nnr_pkg::REG_SOURCE_WIDTH);
      sh = dim(nnr_pkg::REG_SOURCE_HEIGHT);
      dw = dim(nnr_pkg::REG_TARGET_WIDTH);
      dh = dim(nnr_pkg::REG_TARGET_HEIGHT);
      if (r.kind == REQ_WRITE) begin
        if (int'(r.src_col) < sw && int'(r.src_row) < sh)
          store[int'(r.src_row) * DIM + int'(r.src_col)] = r.pixel_in;
      end else begin
        if (int'(r.dst_col) >= dw || int'(r.dst_row) >= dh) begin
          res.pixel       = 8'd0;
          res.coord_error = 1'b1;
        end else begin
          sy = int'(r.dst_row) * sh / dh;
          sx = int'(r.dst_col) * sw / dw;
          res.pixel       = store[sy * DIM + sx];
          res.coord_error = 1'b0;
        end
        awaited.push_back(res);
      end
    endfunction

    function void check_result(logic [7:0] pixel, logic err);
      pixel_rsp_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: pixel_out=%0d coord_error=%0d", pixel, err);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (pixel !== want.pixel) begin
        $error("pixel_out: expected %0d, actual %0d", want.pixel, pixel);
        errors++;
      end
      if (err !== want.coord_error) begin
        $error("coord_error: expected %0d, actual %0d", want.coord_error, err);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   calm;
  bit   loaded [DIM*DIM];   // source pixels already sent to the store

  resize_scoreboard sb = new();

  nnr_req_if req_ch ();
  nnr_rsp_if rsp_ch ();
  nnr_cfg_if cfg_ch ();

  nearest_neighbor_image_resize #(
    .MAX_DIM (DIM)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // response side back-pressure
  always @(posedge clk) begin
    rsp_ch.ready <= !rst && (calm || $urandom_range(0, 99) >= 16);
  end

  // compare each accepted result
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.check_result(rsp_ch.pixel_out, rsp_ch.coord_error);
  end

  function bit idle_now();
    return !calm && ($urandom_range(0, 99) < 16);
  endfunction

  function pixel_req_t random_fields();
    pixel_req_t r;
    r.kind     = req_kind_t'($urandom_range(0, 1));
    r.src_col  = 8'($urandom_range(0, 255));
    r.src_row  = 8'($urandom_range(0, 255));
    r.pixel_in = 8'($urandom_range(0, 255));
    r.dst_col  = 8'($urandom_range(0, 255));
    r.dst_row  = 8'($urandom_range(0, 255));
    return r;
  endfunction

  // present one request, holding valid until it is taken
  task automatic send_request(pixel_req_t r);
    while (idle_now()) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= r.kind;
    req_ch.src_col  <= r.src_col;
    req_ch.src_row  <= r.src_row;
    req_ch.pixel_in <= r.pixel_in;
    req_ch.dst_col  <= r.dst_col;
    req_ch.dst_row  <= r.dst_row;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(r);
  endtask

  task automatic put_pixel(int col, int row, bit [7:0] pix);
    pixel_req_t r;
    r          = random_fields();
    r.kind     = REQ_WRITE;
    r.src_col  = 8'(col);
    r.src_row  = 8'(row);
    r.pixel_in = pix;
    if (col < sb.dim(nnr_pkg::REG_SOURCE_WIDTH) && row < sb.dim(nnr_pkg::REG_SOURCE_HEIGHT))
      loaded[row * DIM + col] = 1'b1;
    send_request(r);
  endtask

  // read a destination pixel, loading its source pixel first if still empty
  task automatic get_pixel(int x, int y);
    pixel_req_t r;
    int sx, sy;
    r         = random_fields();
    r.kind    = REQ_READ;
    r.dst_col = 8'(x);
    r.dst_row = 8'(y);
    if (x < sb.dim(nnr_pkg::REG_TARGET_WIDTH) && y < sb.dim(nnr_pkg::REG_TARGET_HEIGHT)) begin
      sy = y * sb.dim(nnr_pkg::REG_SOURCE_HEIGHT) / sb.dim(nnr_pkg::REG_TARGET_HEIGHT);
      sx = x * sb.dim(nnr_pkg::REG_SOURCE_WIDTH) / sb.dim(nnr_pkg::REG_TARGET_WIDTH);
      if (!loaded[sy * DIM + sx])
        put_pixel(sx, sy, 8'($urandom_range(0, 255)));
    end
    send_request(r);
  endtask

  // let every pending result and any trailing write retire
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic set_reg(nnr_pkg::cfg_reg_t idx, bit [CFG_BITS-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic configure(bit [CFG_BITS-1:0] sw, bit [CFG_BITS-1:0] sh,
                           bit [CFG_BITS-1:0] dw, bit [CFG_BITS-1:0] dh);
    drain();
    set_reg(nnr_pkg::REG_SOURCE_WIDTH, sw);
    set_reg(nnr_pkg::REG_SOURCE_HEIGHT, sh);
    set_reg(nnr_pkg::REG_TARGET_WIDTH, dw);
    set_reg(nnr_pkg::REG_TARGET_HEIGHT, dh);
  endtask

  // mostly in-range writes and reads, some dropped writes and bad reads
  task automatic random_phase(int count);
    int sel, sw, sh, dw, dh;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      sw  = sb.dim(nnr_pkg::REG_SOURCE_WIDTH);
      sh  = sb.dim(nnr_pkg::REG_SOURCE_HEIGHT);
      dw  = sb.dim(nnr_pkg::REG_TARGET_WIDTH);
      dh  = sb.dim(nnr_pkg::REG_TARGET_HEIGHT);
      if (sel < 45) begin
        put_pixel($urandom_range(0, sw - 1), $urandom_range(0, sh - 1),
                  8'($urandom_range(0, 255)));
      end else if (sel < 52 && (sw < DIM || sh < DIM)) begin
        if (sw < DIM && (sh == DIM || $urandom_range(0, 1)))
          put_pixel($urandom_range(sw, 255), $urandom_range(0, 255),
                    8'($urandom_range(0, 255)));
        else
          put_pixel($urandom_range(0, 255), $urandom_range(sh, 255),
                    8'($urandom_range(0, 255)));
      end else if (sel >= 90 && (dw < DIM || dh < DIM)) begin
        if (dw < DIM && (dh == DIM || $urandom_range(0, 1)))
          get_pixel($urandom_range(dw, 255), $urandom_range(0, 255));
        else
          get_pixel($urandom_range(0, 255), $urandom_range(dh, 255));
      end else begin
        get_pixel($urandom_range(0, dw - 1), $urandom_range(0, dh - 1));
      end
    end
  endtask

  // run limit
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // stimulus
  initial begin
    rst             = 1'b1;
    calm            = 1'b0;
    req_ch.valid    = 1'b0;
    req_ch.req_type = 1'b0;
    req_ch.src_col  = '0;
    req_ch.src_row  = '0;
    req_ch.pixel_in = '0;
    req_ch.dst_col  = '0;
    req_ch.dst_row  = '0;
    rsp_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // corners of the default 28x28 image, dropped writes, bad reads
    put_pixel(0, 0, 8'h00);
    put_pixel(27, 27, 8'hFF);
    put_pixel(27, 0, 8'hAA);
    put_pixel(0, 27, 8'h55);
    put_pixel(28, 0, 8'h11);
    put_pixel(0, 28, 8'h22);
    put_pixel(255, 255, 8'hFF);
    get_pixel(0, 0);
    get_pixel(27, 27);
    get_pixel(27, 0);
    get_pixel(0, 27);
    get_pixel(28, 0);
    get_pixel(0, 28);
    get_pixel(255, 255);
    put_pixel(0, 0, 8'hFF);
    get_pixel(0, 0);

    // zero registers behave as one
    configure(9'd0, 9'd0, 9'd0, 9'd0);
    get_pixel(0, 0);
    get_pixel(1, 0);
    get_pixel(0, 1);

    // oversized source registers behave as the full size
    configure(9'd511, 9'd257, 9'd256, 9'd256);
    put_pixel(255, 255, 8'h5A);
    get_pixel(255, 255);
    get_pixel(255, 0);

    // extreme upscale and downscale
    configure(9'd1, 9'd1, 9'd256, 9'd256);
    get_pixel(255, 255);
    configure(9'd256, 9'd256, 9'd1, 9'd1);
    get_pixel(0, 0);

    // random phases over a spread of sizes
    configure(9'd256, 9'd256, 9'd256, 9'd256);
    random_phase(PHASE_LEN);
    configure(9'd16, 9'd16, 9'd256, 9'd256);
    random_phase(PHASE_LEN);
    configure(9'd256, 9'd256, 9'd16, 9'd16);
    calm = 1'b1;
    random_phase(PHASE_LEN);
    calm = 1'b0;
    configure(9'd1, 9'd1, 9'd1, 9'd1);
    random_phase(PHASE_LEN);
    configure(9'd300, 9'd0, 9'd511, 9'd2);
    random_phase(PHASE_LEN);
    repeat (2) begin
      configure(CFG_BITS'($urandom_range(1, 40)), CFG_BITS'($urandom_range(1, 40)),
                CFG_BITS'($urandom_range(1, 40)), CFG_BITS'($urandom_range(1, 40)));
      random_phase(PHASE_LEN);
    end
    configure(CFG_BITS'($urandom_range(0, 511)), CFG_BITS'($urandom_range(0, 511)),
              CFG_BITS'($urandom_range(0, 511)), CFG_BITS'($urandom_range(0, 511)));
    random_phase(PHASE_LEN);

    drain();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ nearest_neighbor_image_resize.f @@
+incdir+rtl/core
rtl/core/nnr_pkg.sv
rtl/core/nnr_ifs.sv
rtl/core/nnr_queue.sv
rtl/core/nnr_front.sv
rtl/core/nnr_back.sv
rtl/core/nearest_neighbor_image_resize.sv
test/tb_nearest_neighbor_image_resize.sv
